[rtl/fibonacci_mod_matrix_power_macros.svh]
// Assertion macros used by the top level to check its own behavior
`ifndef FIBONACCI_MOD_MATRIX_POWER_MACROS_SVH
`define FIBONACCI_MOD_MATRIX_POWER_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define FMP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmp check failed");

// next-cycle implication, ignored while reset is held
`define FMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmp check failed");

`endif

[rtl/fmp_pkg.sv]
// Shared constants, controller state type and controller-to-datapath command type for the Fibonacci modulo block
`timescale 1ns / 1ps

package fmp_pkg;

  localparam int INDEX_WIDTH = 63;
  localparam int BIT_CNT_W   = $clog2(INDEX_WIDTH);
  localparam int MOD_W       = 16;
  localparam int RED_STEPS   = MOD_W + 1;
  localparam int RED_CNT_W   = $clog2(RED_STEPS);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(INDEX_WIDTH - 1);
  localparam logic [RED_CNT_W-1:0] LAST_STEP = RED_CNT_W'(RED_STEPS - 1);
  localparam logic [MOD_W-1:0]     MOD_RESET = 16'd46337;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_RED  = 6'b001000,
    ST_BASE = 6'b010000,
    ST_SPARE = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic red;
    logic base;
  } dp_cmd_t;

endpackage

[rtl/fmp_datapath.sv]
// Matrix entries, shared products, restoring reducers and base-matrix step
`timescale 1ns / 1ps

module fmp_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fmp_pkg::dp_cmd_t                 cmd,
  input  logic [fmp_pkg::INDEX_WIDTH-1:0]  in_index,
  input  logic                             cfg_we,
  input  logic [fmp_pkg::MOD_W-1:0]        cfg_data,
  output logic [fmp_pkg::MOD_W-1:0]        fib_value
);

  logic [fmp_pkg::MOD_W-1:0]       mod_r, mod_nxt;
  logic [fmp_pkg::INDEX_WIDTH-1:0] idx_r, idx_nxt;
  logic [15:0] p_r, p_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [31:0] prod_r [5];
  logic [31:0] prod_nxt [5];
  logic [32:0] rem_r [3];
  logic [32:0] rem_nxt [3];
  logic [32:0] div_r, div_nxt;
  logic [16:0] m_eff;
  logic [15:0] one_mod;
  logic [15:0] sp, sq, sr;

  function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b,
                                          input logic [16:0] m);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= m) begin
      s = s - m;
    end
    return s[15:0];
  endfunction

  assign m_eff   = (mod_r == 16'd0) ? 17'h10000 : {1'b0, mod_r};
  assign one_mod = (mod_r == 16'd1) ? 16'd0 : 16'd1;
  assign sp = rem_r[0][15:0];
  assign sq = rem_r[1][15:0];
  assign sr = rem_r[2][15:0];

  always_comb begin
    mod_nxt = cfg_we ? cfg_data : mod_r;
    idx_nxt = idx_r;
    p_nxt = p_r;
    q_nxt = q_r;
    r_nxt = r_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (cmd.load) begin
      idx_nxt = in_index;
      p_nxt = one_mod;
      q_nxt = 16'd0;
      r_nxt = one_mod;
    end
    if (cmd.mul) begin
      prod_nxt[0] = {16'd0, p_r} * {16'd0, p_r};
      prod_nxt[1] = {16'd0, q_r} * {16'd0, q_r};
      prod_nxt[2] = {16'd0, p_r} * {16'd0, q_r};
      prod_nxt[3] = {16'd0, q_r} * {16'd0, r_r};
      prod_nxt[4] = {16'd0, r_r} * {16'd0, r_r};
    end
    if (cmd.sum) begin
      rem_nxt[0] = {1'b0, prod_r[0]} + {1'b0, prod_r[1]};
      rem_nxt[1] = {1'b0, prod_r[2]} + {1'b0, prod_r[3]};
      rem_nxt[2] = {1'b0, prod_r[1]} + {1'b0, prod_r[4]};
      div_nxt    = {m_eff, 16'd0};
    end
    if (cmd.red) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= div_r) begin
          rem_nxt[i] = rem_r[i] - div_r;
        end
      end
      div_nxt = div_r >> 1;
    end
    if (cmd.base) begin
      idx_nxt = idx_r << 1;
      if (idx_r[fmp_pkg::INDEX_WIDTH-1]) begin
        p_nxt = sq;
        q_nxt = add_mod(sp, sq, m_eff);
        r_nxt = add_mod(sq, sr, m_eff);
      end else begin
        p_nxt = sp;
        q_nxt = sq;
        r_nxt = sr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= fmp_pkg::MOD_RESET;
    end else begin
      mod_r <= mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign fib_value = q_r;

endmodule

[rtl/fmp_ctrl.sv]
// Sequencer over index bits: multiply, sum, reduce and base step per bit
`timescale 1ns / 1ps

module fmp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output fmp_pkg::dp_cmd_t cmd
);

  fmp_pkg::state_t state_r, state_nxt;
  logic [fmp_pkg::BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic [fmp_pkg::RED_CNT_W-1:0] step_r, step_nxt;
  logic valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    step_nxt  = step_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      fmp_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          bit_nxt   = '0;
          state_nxt = fmp_pkg::ST_MUL;
        end
      end
      fmp_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = fmp_pkg::ST_SUM;
      end
      fmp_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        step_nxt  = '0;
        state_nxt = fmp_pkg::ST_RED;
      end
      fmp_pkg::ST_RED: begin
        cmd.red  = 1'b1;
        step_nxt = step_r + fmp_pkg::RED_CNT_W'(1);
        if (step_r == fmp_pkg::LAST_STEP) begin
          state_nxt = fmp_pkg::ST_BASE;
        end
      end
      fmp_pkg::ST_BASE: begin
        cmd.base = 1'b1;
        bit_nxt  = bit_r + fmp_pkg::BIT_CNT_W'(1);
        if (bit_r == fmp_pkg::LAST_BIT) begin
          valid_nxt = 1'b1;
          state_nxt = fmp_pkg::ST_IDLE;
        end else begin
          state_nxt = fmp_pkg::ST_MUL;
        end
      end
      default: begin
        state_nxt = fmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmp_pkg::ST_IDLE;
      bit_r   <= '0;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != fmp_pkg::ST_IDLE);
  assign out_valid = valid_r;

endmodule

[rtl/fibonacci_mod_matrix_power.sv]
// Top level: F(n) mod a configured modulus by 2x2 matrix powering
//
//   channel  ports                          handshake
//   -------  -----------------------------  ------------------------
//   input    in_index                       start high, busy low
//   result   out_fib_value                  out_valid, one cycle
//   config   cfg_data                       cfg_we
//
// A word is accepted only while idle; the next word can be accepted in the
// strobe cycle. Per index bit: products, then sums, then the restoring
// reducers (one quotient bit a cycle), then one base-matrix step.
// Reset (synchronous, rst_n low) returns to idle and loads modulus 46337.
// The result receiver cannot stall; the strobe lasts one cycle.
`timescale 1ns / 1ps
`include "fibonacci_mod_matrix_power_macros.svh"

module fibonacci_mod_matrix_power (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [fmp_pkg::INDEX_WIDTH-1:0]  in_index,
  output logic                             out_valid,
  output logic [fmp_pkg::MOD_W-1:0]        out_fib_value,
  input  logic                             cfg_we,
  input  logic [fmp_pkg::MOD_W-1:0]        cfg_data
);

  fmp_pkg::dp_cmd_t cmd;

  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fmp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_index  (in_index),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .fib_value (out_fib_value)
  );

  `FMP_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `FMP_ASSERT_IMPL(a_valid_idle, clk, rst_n, out_valid, !busy)
  `FMP_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `FMP_ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load, !busy && start)

endmodule
